FILE: src/hsl_to_rgb565_assert.svh
// Assertion macros for the colour conversion block.
`ifndef HSL_TO_RGB565_ASSERT_SVH
`define HSL_TO_RGB565_ASSERT_SVH

// Check that cons holds whenever ante holds, on clk, ignored while in reset.
`define H2R_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that expr never holds, on clk, ignored while in reset.
`define H2R_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: src/h2r565_pkg.sv
package h2r565_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int IN_W      = 17;
    localparam int HUE_W     = 16;
    localparam int POS_W     = 9;
    localparam int FACT_W    = 6;
    localparam int C8_W      = 8;

    localparam int UP_SHIFT   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int DOWN_SHIFT = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int EXT_W      = IN_W + UP_SHIFT;

    localparam int DEG_TURN   = 360;
    localparam int DEG_SIXTH  = 60;
    localparam int DEG_THIRD  = 120;
    localparam int DEG_HALF   = 180;
    localparam int DEG_TWO_THIRDS = 240;
    localparam int RAMP_RND   = DEG_SIXTH / 2;
    localparam int IN_ONE     = 65536;
    localparam int C8_MAX     = 255;

    localparam int HU_W        = HUE_W + 1;
    localparam int HUE_OFFSET  = ((2 ** (HUE_W - 1)) / DEG_TURN + 1) * DEG_TURN;
    localparam int HUE_K       = HU_W + POS_W;
    localparam longint unsigned HUE_RECIP = (64'd1 << HUE_K) / DEG_TURN + 1;
    localparam int HRECIP_W    = HUE_K - 8;
    localparam int HQ_W        = HU_W + HRECIP_W;

    localparam int RAMP_W      = FX_W + FACT_W;
    localparam int RAMP_K      = RAMP_W + FACT_W;
    localparam longint unsigned RAMP_RECIP = (64'd1 << RAMP_K) / DEG_SIXTH + 1;
    localparam int RRECIP_W    = RAMP_K - 5;
    localparam int RPROD_W     = RAMP_W + RRECIP_W;

    localparam int LS_W        = 2 * FX_W;
    localparam int QP_W        = FX_W + 2;
    localparam int SC_W        = FX_W + C8_W;

    localparam int FRONT_STAGES = 3;
    localparam int CHAN_STAGES  = 4;
    localparam int LATENCY      = FRONT_STAGES + CHAN_STAGES;

    localparam logic [15:0] RGB_WHITE = 16'hFFFF;
    localparam logic [15:0] RGB_BLACK = 16'h0000;

    typedef logic [FX_W-1:0]  fx_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam fx_t FX_ONE  = fx_t'(1) << FRAC_BITS;
    localparam fx_t FX_HALF = fx_t'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        fx_t  p;
        fx_t  q;
        pos_t pos;
    } chan_in_t;

    typedef enum logic [1:0] {
        REG_RISE,
        REG_FLAT,
        REG_FALL,
        REG_LOW
    } region_t;

    function automatic fx_t to_fx(input logic [IN_W-1:0] raw);
        logic [IN_W-1:0]  v;
        logic [EXT_W-1:0] e;
        begin
            v = (raw > IN_W'(IN_ONE)) ? IN_W'(IN_ONE) : raw;
            e = (EXT_W'(v) << UP_SHIFT) >> DOWN_SHIFT;
            return fx_t'(e);
        end
    endfunction

endpackage

FILE: src/h2r565_front.sv
module h2r565_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [h2r565_pkg::HUE_W-1:0]    hue_degrees,
    input  logic        [h2r565_pkg::IN_W-1:0]     saturation,
    input  logic        [h2r565_pkg::IN_W-1:0]     lightness,
    output logic                                   out_valid,
    output h2r565_pkg::chan_in_t                   red_in,
    output h2r565_pkg::chan_in_t                   green_in,
    output h2r565_pkg::chan_in_t                   blue_in
);
    import h2r565_pkg::*;

    logic [FRONT_STAGES-1:0] valid_reg;

    logic [HU_W-1:0] hu_reg, hu_next;
    logic [HQ_W-1:0] hq_reg, hq_next;
    fx_t             s1_reg, s1_next, l1_reg, l1_next;

    pos_t            d_reg, d_next;
    logic [LS_W-1:0] ls_reg, ls_next;
    fx_t             s2_reg, l2_reg;

    fx_t             p_reg, p_next, q_reg, q_next;
    pos_t            pr_reg, pr_next, pg_reg, pb_reg, pb_next;

    logic [HU_W-1:0] hquo;
    logic [QP_W-1:0] ls_rnd, q_raw, q_hi, q_lo, p_raw;

    // Stage 1: offset hue positive, estimate quotient by 360, clamp s and l.
    always_comb
    begin
        hu_next = {hue_degrees[HUE_W-1], hue_degrees} + HU_W'(HUE_OFFSET);
        hq_next = HQ_W'(hu_next) * HQ_W'(HUE_RECIP);
        s1_next = to_fx(saturation);
        l1_next = to_fx(lightness);
    end

    // Stage 2: hue remainder and l*s product.
    always_comb
    begin
        hquo    = HU_W'(hq_reg >> HUE_K);
        d_next  = POS_W'(hu_reg - hquo * HU_W'(DEG_TURN));
        ls_next = LS_W'(l1_reg) * LS_W'(s1_reg);
    end

    // Stage 3: q, p and the three channel positions.
    always_comb
    begin
        ls_rnd = QP_W'((ls_reg + LS_W'(FX_HALF)) >> FRAC_BITS);
        if (l2_reg < FX_HALF)
        begin
            q_raw = QP_W'(l2_reg) + ls_rnd;
        end
        else
        begin
            q_raw = QP_W'(l2_reg) + QP_W'(s2_reg) - ls_rnd;
        end
        q_hi = (q_raw > QP_W'(FX_ONE)) ? QP_W'(FX_ONE) : q_raw;
        q_lo = (q_hi < QP_W'(l2_reg)) ? QP_W'(l2_reg) : q_hi;
        p_raw = (QP_W'(l2_reg) << 1) - q_lo;
        q_next = fx_t'(q_lo);
        p_next = (p_raw > q_lo) ? fx_t'(q_lo) : fx_t'(p_raw);

        if (d_reg >= pos_t'(DEG_TURN - DEG_THIRD))
        begin
            pr_next = d_reg - pos_t'(DEG_TURN - DEG_THIRD);
        end
        else
        begin
            pr_next = d_reg + pos_t'(DEG_THIRD);
        end
        if (d_reg >= pos_t'(DEG_TURN - DEG_TWO_THIRDS))
        begin
            pb_next = d_reg - pos_t'(DEG_TURN - DEG_TWO_THIRDS);
        end
        else
        begin
            pb_next = d_reg + pos_t'(DEG_TWO_THIRDS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        hu_reg <= hu_next;
        hq_reg <= hq_next;
        s1_reg <= s1_next;
        l1_reg <= l1_next;
        d_reg  <= d_next;
        ls_reg <= ls_next;
        s2_reg <= s1_reg;
        l2_reg <= l1_reg;
        p_reg  <= p_next;
        q_reg  <= q_next;
        pr_reg <= pr_next;
        pg_reg <= d_reg;
        pb_reg <= pb_next;
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];
    assign red_in    = '{p: p_reg, q: q_reg, pos: pr_reg};
    assign green_in  = '{p: p_reg, q: q_reg, pos: pg_reg};
    assign blue_in   = '{p: p_reg, q: q_reg, pos: pb_reg};

endmodule

FILE: src/h2r565_chan.sv
module h2r565_chan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  h2r565_pkg::chan_in_t              ch_in,
    output logic                              out_valid,
    output logic [h2r565_pkg::C8_W-1:0]       level
);
    import h2r565_pkg::*;

    logic [CHAN_STAGES-1:0] valid_reg;

    region_t            reg4_reg, reg4_next, reg5_reg;
    logic [RAMP_W-1:0]  x_reg, x_next;
    fx_t                p4_reg, q4_reg, p5_reg, q5_reg;
    logic [RPROD_W-1:0] prod_reg, prod_next;
    fx_t                c_reg, c_next;
    logic [C8_W-1:0]    level_reg, level_next;

    fx_t                 span, quot, c_cl;
    logic [FACT_W-1:0]   fact;
    logic [SC_W-1:0]     sc;
    logic [SC_W-FRAC_BITS-1:0] v8;

    // Stage 4: pick the hue segment and scale the span.
    always_comb
    begin
        span = ch_in.q - ch_in.p;
        if (ch_in.pos < pos_t'(DEG_SIXTH))
        begin
            reg4_next = REG_RISE;
            fact      = FACT_W'(ch_in.pos);
        end
        else if (ch_in.pos < pos_t'(DEG_HALF))
        begin
            reg4_next = REG_FLAT;
            fact      = '0;
        end
        else if (ch_in.pos < pos_t'(DEG_TWO_THIRDS))
        begin
            reg4_next = REG_FALL;
            fact      = FACT_W'(pos_t'(DEG_TWO_THIRDS) - ch_in.pos);
        end
        else
        begin
            reg4_next = REG_LOW;
            fact      = '0;
        end
        x_next = RAMP_W'(span) * RAMP_W'(fact) + RAMP_W'(RAMP_RND);
    end

    // Stage 5: divide by 60 through the reciprocal.
    always_comb
    begin
        prod_next = RPROD_W'(x_reg) * RPROD_W'(RAMP_RECIP);
    end

    // Stage 6: channel value.
    always_comb
    begin
        quot = fx_t'(prod_reg >> RAMP_K);
        case (reg5_reg)
            REG_RISE: c_next = p5_reg + quot;
            REG_FALL: c_next = p5_reg + quot;
            REG_FLAT: c_next = q5_reg;
            REG_LOW:  c_next = p5_reg;
            default:  c_next = p5_reg;
        endcase
    end

    // Stage 7: scale to 8 bits with round half up.
    always_comb
    begin
        c_cl = (c_reg > FX_ONE) ? FX_ONE : c_reg;
        sc   = (SC_W'(c_cl) << C8_W) - SC_W'(c_cl) + SC_W'(FX_HALF);
        v8   = (SC_W - FRAC_BITS)'(sc >> FRAC_BITS);
        level_next = (v8 > (SC_W - FRAC_BITS)'(C8_MAX)) ? C8_W'(C8_MAX) : C8_W'(v8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CHAN_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        reg4_reg  <= reg4_next;
        x_reg     <= x_next;
        p4_reg    <= ch_in.p;
        q4_reg    <= ch_in.q;
        reg5_reg  <= reg4_reg;
        prod_reg  <= prod_next;
        p5_reg    <= p4_reg;
        q5_reg    <= q4_reg;
        c_reg     <= c_next;
        level_reg <= level_next;
    end

    assign out_valid = valid_reg[CHAN_STAGES-1];
    assign level     = level_reg;

endmodule

FILE: src/hsl_to_rgb565.sv
// HSL to RGB565 colour conversion, fully pipelined.
// done rises once an item taken with start has passed the front stages and then the channel stages.
// Throughput: one item per cycle; busy is always low.
// The result stands for one cycle and cannot be stalled.
// Reset (rst_n low, asynchronous) drops every item in flight.
module hsl_to_rgb565 (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [h2r565_pkg::HUE_W-1:0]    hue_degrees,
    input  logic        [h2r565_pkg::IN_W-1:0]     saturation,
    input  logic        [h2r565_pkg::IN_W-1:0]     lightness,
    output logic                                   done,
    output logic        [15:0]                     rgb565
);
    import h2r565_pkg::*;

    `include "hsl_to_rgb565_assert.svh"

    logic     front_valid;
    chan_in_t red_in, green_in, blue_in;
    logic     done_r, done_g, done_b;
    logic [C8_W-1:0] r8, g8, b8;

    h2r565_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .hue_degrees (hue_degrees),
        .saturation  (saturation),
        .lightness   (lightness),
        .out_valid   (front_valid),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in)
    );

    h2r565_chan u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .ch_in     (red_in),
        .out_valid (done_r),
        .level     (r8)
    );

    h2r565_chan u_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .ch_in     (green_in),
        .out_valid (done_g),
        .level     (g8)
    );

    h2r565_chan u_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .ch_in     (blue_in),
        .out_valid (done_b),
        .level     (b8)
    );

    assign busy   = 1'b0;
    assign done   = done_r;
    assign rgb565 = {r8[C8_W-1:3], g8[C8_W-1:2], b8[C8_W-1:3]};

    `H2R_ASSERT_IMPL(a_lanes_aligned, done_r || done_g || done_b, done_r && done_g && done_b, "channel lanes out of step")
    `H2R_ASSERT_IMPL(a_latency, done, $past(start, LATENCY), "result without a matching item")
    `H2R_ASSERT_IMPL(a_full_light, done && $past(start && lightness[IN_W-1], LATENCY), rgb565 == RGB_WHITE, "full lightness not white")
    `H2R_ASSERT_IMPL(a_zero_light, done && $past(start && (lightness == '0), LATENCY), rgb565 == RGB_BLACK, "zero lightness not black")

endmodule
